>>> sv/tsa_pkg.sv
package tsa_pkg;

	localparam int MAX_SIZE_LOG2 = 12;

	// column/row counter width
	localparam int CNT_W      = MAX_SIZE_LOG2;
	localparam int LOG_W      = 4;
	localparam int BPP_W      = 3;
	localparam int PIX_W      = 32;
	localparam int OFF_W      = 26;
	// swizzled pixel index before byte scaling
	localparam int SUM_W      = 2 * MAX_SIZE_LOG2 + 2;
	localparam int SH_W       = $clog2(SUM_W);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	// skid queue between front and back
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LOG2  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LOG2 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BPP         = 2'd2;

	localparam logic [LOG_W-1:0] WIDTH_LOG2_RST  = 4'd0;
	localparam logic [LOG_W-1:0] HEIGHT_LOG2_RST = 4'd0;
	localparam logic [BPP_W-1:0] BPP_RST         = 3'd4;

	typedef struct packed {
		logic [LOG_W-1:0] width_log2;
		logic [LOG_W-1:0] height_log2;
		logic [BPP_W-1:0] bytes_per_pixel;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] column;
		logic [CNT_W-1:0] row;
		logic [PIX_W-1:0] pixel;
		logic             last;
	} entry_t;

	// saturate a log2 register at the largest supported size
	function automatic logic [SH_W-1:0] clamp_log2(input logic [LOG_W-1:0] v);
		logic [SH_W-1:0] r;
		if (int'(v) > MAX_SIZE_LOG2) begin
			r = SH_W'(MAX_SIZE_LOG2);
		end else begin
			r = SH_W'(v);
		end
		return r;
	endfunction

	// place bit b of v at position 2*b
	function automatic logic [2*CNT_W-1:0] spread_bits(input logic [CNT_W-1:0] v);
		logic [2*CNT_W-1:0] r;
		r = '0;
		for (int b = 0; b < CNT_W; b++) begin
			r[2*b] = v[b];
		end
		return r;
	endfunction

endpackage

>>> sv/tsa_front.sv
module tsa_front import tsa_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   push,
	input  logic [PIX_W-1:0] pixel_value,
	output entry_t entry
);

	logic [CNT_W-1:0] column_q;
	logic [CNT_W-1:0] row_q;
	logic [SH_W-1:0]  wl;
	logic [SH_W-1:0]  hl;
	logic [CNT_W:0]   col_inc;
	logic [CNT_W:0]   row_inc;
	logic             col_end;
	logic             row_end;

	always_comb begin
		wl      = clamp_log2(cfg.width_log2);
		hl      = clamp_log2(cfg.height_log2);
		col_inc = {1'b0, column_q} + (CNT_W+1)'(1);
		row_inc = {1'b0, row_q} + (CNT_W+1)'(1);
		col_end = col_inc >= ((CNT_W+1)'(1) << wl);
		row_end = row_inc >= ((CNT_W+1)'(1) << hl);
	end

	assign entry.column = column_q;
	assign entry.row    = row_q;
	assign entry.pixel  = pixel_value;
	assign entry.last   = col_end && row_end;

	// raster walk: wrap the column at the line end, the row at the image end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (push) begin
			if (col_end) begin
				column_q <= '0;
				if (row_end) begin
					row_q <= '0;
				end else begin
					row_q <= row_inc[CNT_W-1:0];
				end
			end else begin
				column_q <= col_inc[CNT_W-1:0];
			end
		end
	end

endmodule

>>> sv/tsa_queue.sv
module tsa_queue import tsa_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output logic   head_valid,
	output logic   full
);

	entry_t            slot_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head       = slot_q[rptr_q];
	assign head_valid = count_q != '0;
	assign full       = count_q == QCNT_W'(QDEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (int'(wptr_q) == QDEPTH - 1) ? '0 : wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= (int'(rptr_q) == QDEPTH - 1) ? '0 : rptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

>>> sv/tsa_back.sv
module tsa_back import tsa_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  entry_t head,
	input  logic   head_valid,
	output logic   pop,
	output logic   out_valid,
	input  logic   out_stall,
	output logic [OFF_W-1:0] dest_offset,
	output logic [PIX_W-1:0] pixel_out,
	output logic             last_pixel
);

	logic [SH_W-1:0]  wl;
	logic [SH_W-1:0]  hl1;
	logic [CNT_W-1:0] y_lo;
	logic [CNT_W-1:0] y_hi;
	logic [CNT_W-1:0] x_lo;
	logic [CNT_W-1:0] x_hi;
	logic [SUM_W-1:0] sy;
	logic [SUM_W-1:0] sx;

	logic             valid_s1;
	logic [SUM_W-1:0] sum_s1;
	logic [PIX_W-1:0] pixel_s1;
	logic             last_s1;

	logic             valid_s2;
	logic [OFF_W-1:0] offset_s2;
	logic [PIX_W-1:0] pixel_s2;
	logic             last_s2;

	logic             adv_s1;
	logic             adv_s2;

	// row bits to odd positions, column bits to even positions; the part
	// beyond the block edge is a block number placed above the interleave
	always_comb begin
		wl   = clamp_log2(cfg.width_log2);
		hl1  = clamp_log2(cfg.height_log2) + SH_W'(1);
		y_lo = head.row & ~({CNT_W{1'b1}} << wl);
		y_hi = head.row >> wl;
		x_lo = head.column & ~({CNT_W{1'b1}} << hl1);
		x_hi = head.column >> hl1;
		sy   = (SUM_W'(spread_bits(y_lo)) << 1) | (SUM_W'(y_hi) << (wl << 1));
		sx   = SUM_W'(spread_bits(x_lo)) | (SUM_W'(x_hi) << ((hl1 << 1) - SH_W'(1)));
	end

	assign adv_s2 = !valid_s2 || !out_stall;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign pop    = head_valid && adv_s1;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			sum_s1   <= sx + sy;
			pixel_s1 <= head.pixel;
			last_s1  <= head.last;
		end
		if (adv_s2) begin
			offset_s2 <= OFF_W'(sum_s1 * cfg.bytes_per_pixel);
			pixel_s2  <= pixel_s1;
			last_s2   <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= head_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign out_valid   = valid_s2;
	assign dest_offset = offset_s2;
	assign pixel_out   = pixel_s2;
	assign last_pixel  = last_s2;

endmodule

>>> sv/texture_swizzle_address_top.sv
// Morton (Z-order) swizzle address generator. Feed texture pixels in raster
// order on the input channel; each comes back on the output channel with its
// byte offset in the swizzled layout, the pixel value unchanged, and a flag
// on the final pixel of the image. Column and row counters run internally,
// start at zero after reset and wrap at the image end; register writes do
// not clear them. Width and height are powers of two given as log2 (values
// above 12 act as 12); non-square images are folded into square or 2:1
// blocks. The offset is the pixel index times bytes_per_pixel, low 26 bits.
// Throughput is one pixel per clock while neither in_stall nor out_stall holds
// the flow. The queue slot is written at the input transfer, then the two
// back-end stages (interleave and add, then byte scaling) are registered in
// turn before output valid rises. A two-entry queue parts the counter front
// end from the address back end, so input transfers continue until the queue
// fills while a result waits. Write configuration only while no pixel is in
// flight; cfg_ready is always high.
module texture_swizzle_address_top import tsa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// pixel input
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PIX_W-1:0]      pixel_value,
	// addressed pixel output
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [OFF_W-1:0]      dest_offset,
	output logic [PIX_W-1:0]      pixel_out,
	output logic                  last_pixel
);

	cfg_t   cfg_q;
	entry_t push_entry;
	entry_t head;
	logic   head_valid;
	logic   pop;
	logic   full;
	logic   push;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width_log2      <= WIDTH_LOG2_RST;
			cfg_q.height_log2     <= HEIGHT_LOG2_RST;
			cfg_q.bytes_per_pixel <= BPP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WIDTH_LOG2:  cfg_q.width_log2      <= cfg_data[LOG_W-1:0];
				CFG_HEIGHT_LOG2: cfg_q.height_log2     <= cfg_data[LOG_W-1:0];
				CFG_BPP:         cfg_q.bytes_per_pixel <= cfg_data[BPP_W-1:0];
				default: ;
			endcase
		end
	end

	// hold the input while the queue is full
	assign in_stall = full;
	assign push     = in_valid && !full;

	// front end: raster counters, last-pixel detect
	tsa_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.push        (push),
		.pixel_value (pixel_value),
		.entry       (push_entry)
	);

	tsa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (full)
	);

	// back end: interleave, block fold, byte scaling, output register
	tsa_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.dest_offset (dest_offset),
		.pixel_out   (pixel_out),
		.last_pixel  (last_pixel)
	);

endmodule
